// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the stepper dial pulse generator.
// Define NO_ASSERTIONS to compile every use to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/sdp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper dial pulse generator package
// Field widths, command codes, request type and the dial modulo table.
// ----------------------------------------------------------------------------
package sdp_pkg;

    localparam int unsigned DIAL_W            = 8;
    localparam int unsigned COUNT_W           = 16;
    localparam int unsigned HP_W              = 16;
    localparam int unsigned STEPS_PER_REV_DEF = 200;
    localparam int unsigned LUT_DEPTH         = 256;

    typedef enum logic [1:0] {
        FUNC_TICK       = 2'd0,
        FUNC_MOVE       = 2'd1,
        FUNC_GOTO_RIGHT = 2'd2,
        FUNC_GOTO_LEFT  = 2'd3
    } func_t;

    typedef struct packed {
        func_t                func;
        logic [COUNT_W-1:0]   step_count;
        logic                 backward;
        logic [DIAL_W-1:0]    target;
        logic [HP_W-1:0]      half_period_us;
    } req_t;

    typedef logic [DIAL_W-1:0] dial_lut_t [LUT_DEPTH];

    // Reduces every byte value into the dial range by repeated subtraction.
    function automatic dial_lut_t build_dial_mod(int unsigned n);
        dial_lut_t   lut;
        int unsigned v;
        for (int i = 0; i < LUT_DEPTH; i++) begin
            v = i;
            for (int k = 0; k < LUT_DEPTH; k++) begin
                if (v >= n) begin
                    v = v - n;
                end
            end
            lut[i] = v[DIAL_W-1:0];
        end
        return lut;
    endfunction

endpackage

// ===== hw/rtl/sdp_req_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper dial request stage
// Input register for one request; reduces the target into the dial range.
// ----------------------------------------------------------------------------
module sdp_req_stage #(
    parameter int unsigned STEPS_PER_REV = sdp_pkg::STEPS_PER_REV_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic [1:0]                   func,
    input  logic [sdp_pkg::COUNT_W-1:0]  step_count,
    input  logic                         backward,
    input  logic [sdp_pkg::DIAL_W-1:0]   target,
    input  logic [sdp_pkg::HP_W-1:0]     half_period_us,
    input  logic                         core_ready,
    output logic                         item_valid,
    output sdp_pkg::req_t                item
);

    localparam sdp_pkg::dial_lut_t TGT_MOD = sdp_pkg::build_dial_mod(STEPS_PER_REV);

    logic          valid_reg;
    logic          valid_next;
    sdp_pkg::req_t item_reg;
    sdp_pkg::req_t item_next;
    logic          load_en;

    assign load_en = !valid_reg || core_ready;

    always_comb
    begin
        valid_next = load_en ? req_valid : valid_reg;
        item_next  = item_reg;
        if (load_en && req_valid)
        begin
            item_next.func           = sdp_pkg::func_t'(func);
            item_next.step_count     = step_count;
            item_next.backward       = backward;
            item_next.target         = TGT_MOD[target];
            item_next.half_period_us = half_period_us;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign req_stall  = !load_en;
    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hw/rtl/sdp_motion_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper dial motion core; registers the result of each request.
// Holds the move state; applies one request per cycle unless the result stalls.
// ----------------------------------------------------------------------------
module sdp_motion_core #(
    parameter int unsigned STEPS_PER_REV = sdp_pkg::STEPS_PER_REV_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  sdp_pkg::req_t               item,
    output logic                        core_ready,
    input  logic                        driver_enable,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic                        step_pin,
    output logic                        dir_pin,
    output logic                        enable_n,
    output logic                        busy_res,
    output logic [sdp_pkg::DIAL_W-1:0]  dial_position,
    output logic                        rejected
);

    localparam int unsigned DW = sdp_pkg::DIAL_W;
    localparam int unsigned WW = sdp_pkg::DIAL_W + 1;
    localparam int unsigned CW = sdp_pkg::COUNT_W;
    localparam int unsigned HW = sdp_pkg::HP_W;
    localparam logic [WW-1:0] N_WIDE = WW'(STEPS_PER_REV);
    localparam logic [DW-1:0] N_LAST = DW'(STEPS_PER_REV - 1);

    logic [DW-1:0] position_reg,   position_next;
    logic [CW-1:0] steps_left_reg, steps_left_next;
    logic [HW-1:0] half_period_reg, half_period_next;
    logic [HW-1:0] tick_count_reg, tick_count_next;
    logic          pulse_high_reg, pulse_high_next;
    logic          backward_reg,   backward_next;
    logic          res_valid_reg,  res_valid_next;
    logic          rejected_reg,   rejected_next;
    logic          step_pin_reg,   dir_pin_reg, enable_n_reg, busy_reg;
    logic [DW-1:0] dial_reg;

    logic          take;
    logic [HW-1:0] hp_eff;
    logic [HW-1:0] tick_inc;
    logic [WW-1:0] pos_inc;
    logic [WW-1:0] dist_right, dist_left;
    logic [WW-1:0] dist_right_mod, dist_left_mod;
    logic [CW-1:0] steps_dec;
    logic          start;
    logic [CW-1:0] start_count;
    logic          start_back;

    assign core_ready = !res_valid_reg || !res_stall;
    assign take       = item_valid && core_ready;

    assign hp_eff    = (half_period_reg == '0) ? HW'(1) : half_period_reg;
    assign tick_inc  = tick_count_reg + HW'(1);
    assign pos_inc   = {1'b0, position_reg} + WW'(1);
    assign steps_dec = steps_left_reg - CW'(1);

    assign dist_right     = {1'b0, position_reg} + N_WIDE - {1'b0, item.target};
    assign dist_left      = {1'b0, item.target} + N_WIDE - {1'b0, position_reg};
    assign dist_right_mod = (dist_right >= N_WIDE) ? dist_right - N_WIDE : dist_right;
    assign dist_left_mod  = (dist_left >= N_WIDE) ? dist_left - N_WIDE : dist_left;

    always_comb
    begin
        position_next    = position_reg;
        steps_left_next  = steps_left_reg;
        half_period_next = half_period_reg;
        tick_count_next  = tick_count_reg;
        pulse_high_next  = pulse_high_reg;
        backward_next    = backward_reg;
        rejected_next    = 1'b0;
        start            = 1'b0;
        start_count      = item.step_count;
        start_back       = item.backward;

        unique case (item.func)
            sdp_pkg::FUNC_TICK:
            begin
                start = 1'b0;
            end
            sdp_pkg::FUNC_MOVE:
            begin
                start       = 1'b1;
                start_count = item.step_count;
                start_back  = item.backward;
            end
            sdp_pkg::FUNC_GOTO_RIGHT:
            begin
                start       = 1'b1;
                start_count = CW'(dist_right_mod[DW-1:0]);
                start_back  = 1'b1;
            end
            sdp_pkg::FUNC_GOTO_LEFT:
            begin
                start       = 1'b1;
                start_count = CW'(dist_left_mod[DW-1:0]);
                start_back  = 1'b0;
            end
            default:
            begin
                start = 1'b0;
            end
        endcase

        if (item.func == sdp_pkg::FUNC_TICK)
        begin
            if (steps_left_reg != '0)
            begin
                if (tick_inc < hp_eff)
                begin
                    tick_count_next = tick_inc;
                end
                else
                begin
                    tick_count_next = '0;
                    if (pulse_high_reg)
                    begin
                        pulse_high_next = 1'b0;
                    end
                    else
                    begin
                        if (backward_reg)
                        begin
                            position_next = (position_reg == '0) ? N_LAST : position_reg - DW'(1);
                        end
                        else
                        begin
                            position_next = (pos_inc >= N_WIDE) ? '0 : pos_inc[DW-1:0];
                        end
                        steps_left_next = steps_dec;
                        pulse_high_next = (steps_dec != '0);
                    end
                end
            end
        end
        else if (steps_left_reg != '0)
        begin
            rejected_next = 1'b1;
        end
        else if (start)
        begin
            backward_next    = start_back;
            half_period_next = item.half_period_us;
            steps_left_next  = start_count;
            tick_count_next  = '0;
            pulse_high_next  = (start_count != '0);
        end
    end

    assign res_valid_next = core_ready ? item_valid : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= '0;
            steps_left_reg  <= '0;
            half_period_reg <= '0;
            tick_count_reg  <= '0;
            pulse_high_reg  <= 1'b0;
            backward_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (take)
            begin
                position_reg    <= position_next;
                steps_left_reg  <= steps_left_next;
                half_period_reg <= half_period_next;
                tick_count_reg  <= tick_count_next;
                pulse_high_reg  <= pulse_high_next;
                backward_reg    <= backward_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            step_pin_reg <= pulse_high_next;
            dir_pin_reg  <= backward_next;
            enable_n_reg <= !driver_enable;
            busy_reg     <= (steps_left_next != '0);
            dial_reg     <= position_next;
            rejected_reg <= rejected_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign step_pin      = step_pin_reg;
    assign dir_pin       = dir_pin_reg;
    assign enable_n      = enable_n_reg;
    assign busy_res      = busy_reg;
    assign dial_position = dial_reg;
    assign rejected      = rejected_reg;

endmodule

// ===== hw/rtl/stepper_dial_pulse_generator.sv =====
`timescale 1ns / 1ps
// Throughput: one request per cycle unless the result stalls; move state is registered.
// The request register and the result register decouple the two handshakes.
// Reset: asynchronous, active low; clears the dial position, the move state and both
// valid flags, and sets the driver enable register to one.
// ----------------------------------------------------------------------------
// Stepper dial pulse generator
// Step and direction pulse generator for a stepper that turns a dial.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stepper_dial_pulse_generator #(
    parameter int unsigned STEPS_PER_REV = sdp_pkg::STEPS_PER_REV_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_wdata,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [1:0]                  func,
    input  logic [sdp_pkg::COUNT_W-1:0] step_count,
    input  logic                        backward,
    input  logic [sdp_pkg::DIAL_W-1:0]  target,
    input  logic [sdp_pkg::HP_W-1:0]    half_period_us,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic                        step_pin,
    output logic                        dir_pin,
    output logic                        enable_n,
    output logic                        busy_res,
    output logic [sdp_pkg::DIAL_W-1:0]  dial_position,
    output logic                        rejected
);

    logic          driver_enable_reg;
    logic          driver_enable_next;
    logic          core_ready;
    logic          item_valid;
    sdp_pkg::req_t item;

    assign driver_enable_next = cfg_we ? cfg_wdata : driver_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            driver_enable_reg <= 1'b1;
        end
        else
        begin
            driver_enable_reg <= driver_enable_next;
        end
    end

    sdp_req_stage #(
        .STEPS_PER_REV (STEPS_PER_REV)
    ) u_req_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .func           (func),
        .step_count     (step_count),
        .backward       (backward),
        .target         (target),
        .half_period_us (half_period_us),
        .core_ready     (core_ready),
        .item_valid     (item_valid),
        .item           (item)
    );

    sdp_motion_core #(
        .STEPS_PER_REV (STEPS_PER_REV)
    ) u_motion_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .core_ready    (core_ready),
        .driver_enable (driver_enable_reg),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .step_pin      (step_pin),
        .dir_pin       (dir_pin),
        .enable_n      (enable_n),
        .busy_res      (busy_res),
        .dial_position (dial_position),
        .rejected      (rejected)
    );

    `ASSERT_IMPL(a_pulse_busy, clk, rst_n, res_valid && step_pin, busy_res, "step pin high while idle")
    `ASSERT_IMPL(a_dial_range, clk, rst_n, res_valid, dial_position < sdp_pkg::DIAL_W'(STEPS_PER_REV), "dial position out of range")
    `ASSERT_IMPL(a_reject_busy, clk, rst_n, res_valid && rejected, busy_res, "rejected request while idle")
    `ASSERT_IMPL(a_stall_cause, clk, rst_n, req_stall, res_valid && res_stall, "request stalled without a stalled result")

endmodule

// ===== tb/stepper_dial_pulse_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper dial pulse checker
// Watches the request, result and configuration ports of the pulse generator,
// predicts the pin levels, dial position and status after every request, and
// compares each returned result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module stepper_dial_pulse_checker
    import sdp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                req_valid,
    input  logic                req_stall,
    input  req_t                req,
    input  logic                res_valid,
    input  logic                res_stall,
    input  logic                step_pin,
    input  logic                dir_pin,
    input  logic                enable_n,
    input  logic                busy_res,
    input  logic [DIAL_W-1:0]   dial_position,
    input  logic                rejected,
    input  logic                end_of_run,
    output int                  error_count
);

    localparam int unsigned DIAL_STEPS = STEPS_PER_REV_DEF;

    typedef struct packed {
        logic              step;
        logic              dir;
        logic              en_n;
        logic              busy;
        logic [DIAL_W-1:0] pos;
        logic              rej;
    } dial_status_t;

    logic               drv_enable;
    logic [DIAL_W-1:0]  dial_pos;
    logic [COUNT_W-1:0] steps_remaining;
    logic [HP_W-1:0]    latched_half;
    logic [HP_W-1:0]    tick_ctr;
    logic               pin_high;
    logic               dir_back;

    dial_status_t expected_status[$];
    dial_status_t got;
    dial_status_t want;
    int           result_idx = 0;
    int           mismatches = 0;
    bit           leftover_checked = 1'b0;

    assign error_count = mismatches;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] g,
                                 input logic [7:0] w);
        if (g !== w) begin
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      result_idx, name, g, w));
        end
    endtask

    function automatic void start_motion(input logic [COUNT_W-1:0] count, input logic back,
                                         input logic [HP_W-1:0] hp);
        dir_back        = back;
        latched_half    = hp;
        steps_remaining = count;
        tick_ctr        = '0;
        pin_high        = (count != 0);
    endfunction

    task automatic predict_status(input req_t r, output dial_status_t s);
        int unsigned tgt_mod;
        int unsigned hp_eff;
        logic        rej;
        rej     = 1'b0;
        tgt_mod = r.target % DIAL_STEPS;
        if (r.func == FUNC_TICK) begin
            if (steps_remaining != 0) begin
                hp_eff   = (latched_half == 0) ? 1 : latched_half;
                tick_ctr = tick_ctr + 1'b1;
                if (tick_ctr >= hp_eff) begin
                    tick_ctr = '0;
                    if (pin_high) begin
                        pin_high = 1'b0;
                    end
                    else begin
                        if (dir_back) begin
                            dial_pos = (dial_pos == 0) ? DIAL_W'(DIAL_STEPS - 1) : dial_pos - 1'b1;
                        end
                        else begin
                            dial_pos = (dial_pos + 1 >= DIAL_STEPS) ? '0 : dial_pos + 1'b1;
                        end
                        steps_remaining = steps_remaining - 1'b1;
                        pin_high        = (steps_remaining != 0);
                    end
                end
            end
        end
        else if (steps_remaining != 0) begin
            rej = 1'b1;
        end
        else if (r.func == FUNC_MOVE) begin
            start_motion(r.step_count, r.backward, r.half_period_us);
        end
        else if (r.func == FUNC_GOTO_RIGHT) begin
            start_motion(COUNT_W'((dial_pos + DIAL_STEPS - tgt_mod) % DIAL_STEPS), 1'b1,
                         r.half_period_us);
        end
        else begin
            start_motion(COUNT_W'((tgt_mod + DIAL_STEPS - dial_pos) % DIAL_STEPS), 1'b0,
                         r.half_period_us);
        end
        s.step = pin_high;
        s.dir  = dir_back;
        s.en_n = ~drv_enable;
        s.busy = (steps_remaining != 0);
        s.pos  = dial_pos;
        s.rej  = rej;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            drv_enable      = 1'b1;
            dial_pos        = '0;
            steps_remaining = '0;
            latched_half    = '0;
            tick_ctr        = '0;
            pin_high        = 1'b0;
            dir_back        = 1'b0;
            expected_status.delete();
        end
        else begin
            if (cfg_we) begin
                drv_enable = cfg_wdata;
            end
            if (res_valid && !res_stall) begin
                got = '{step: step_pin, dir: dir_pin, en_n: enable_n, busy: busy_res,
                        pos: dial_position, rej: rejected};
                if (expected_status.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              result_idx));
                end
                else begin
                    want = expected_status.pop_front();
                    compare_field("step_pin", 8'(got.step), 8'(want.step));
                    compare_field("dir_pin", 8'(got.dir), 8'(want.dir));
                    compare_field("enable_n", 8'(got.en_n), 8'(want.en_n));
                    compare_field("busy_res", 8'(got.busy), 8'(want.busy));
                    compare_field("dial_position", got.pos, want.pos);
                    compare_field("rejected", 8'(got.rej), 8'(want.rej));
                end
                result_idx++;
            end
            if (req_valid && !req_stall) begin
                predict_status(req, want);
                expected_status.push_back(want);
            end
            if (end_of_run && !leftover_checked) begin
                leftover_checked = 1'b1;
                if (expected_status.size() != 0) begin
                    report_mismatch($sformatf("%0d expected results never arrived",
                                              expected_status.size()));
                end
            end
        end
    end

endmodule

// ===== tb/tb_stepper_dial_pulse_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper dial pulse generator testbench
// Drives relative moves, go-to commands in both directions, commands that
// arrive while a move runs, and microsecond ticks, under several handshake
// idle mixes and driver enable settings; a separate checker predicts results.
// ----------------------------------------------------------------------------
module tb_stepper_dial_pulse_generator;
    import sdp_pkg::*;

    localparam int DIAL_STEPS   = STEPS_PER_REV_DEF;
    localparam int RANDOM_ITEMS = 1900;
    localparam int CYCLE_LIMIT  = 400000;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_wdata;
    logic              req_valid;
    logic              req_stall;
    req_t              req;
    logic              res_valid;
    logic              res_stall;
    logic              step_pin;
    logic              dir_pin;
    logic              enable_n;
    logic              busy_res;
    logic [DIAL_W-1:0] dial_position;
    logic              rejected;
    logic              end_of_run;
    int                fail_count;

    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                reqs_done      = 0;
    int                commands_sent  = 0;
    int                results_done   = 0;
    int                reject_seen    = 0;
    int                last_idle_idx  = -1;
    logic [DIAL_W-1:0] last_pos       = '0;
    int                cycle_count    = 0;

    stepper_dial_pulse_generator DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .func           (req.func),
        .step_count     (req.step_count),
        .backward       (req.backward),
        .target         (req.target),
        .half_period_us (req.half_period_us),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .step_pin       (step_pin),
        .dir_pin        (dir_pin),
        .enable_n       (enable_n),
        .busy_res       (busy_res),
        .dial_position  (dial_position),
        .rejected       (rejected)
    );

    stepper_dial_pulse_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .step_pin      (step_pin),
        .dir_pin       (dir_pin),
        .enable_n      (enable_n),
        .busy_res      (busy_res),
        .dial_position (dial_position),
        .rejected      (rejected),
        .end_of_run    (end_of_run),
        .error_count   (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (res_valid && !res_stall)
        begin
            results_done <= results_done + 1;
            last_pos     <= dial_position;
            if (!busy_res)
            begin
                last_idle_idx <= results_done;
            end
            if (rejected)
            begin
                reject_seen <= reject_seen + 1;
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped by the cycle limit after %0d cycles.", cycle_count);
        $display("tb_stepper_dial_pulse_generator NOT OK");
        $finish;
    end

    function automatic req_t random_request();
        req_t r;
        r.func           = func_t'($urandom_range(3));
        r.step_count     = 16'($urandom);
        r.backward       = 1'($urandom);
        r.target         = 8'($urandom);
        r.half_period_us = 16'($urandom);
        return r;
    endfunction

    function automatic req_t random_command();
        req_t r;
        r      = random_request();
        r.func = func_t'($urandom_range(3, 1));
        return r;
    endfunction

    task automatic send_request(input req_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        reqs_done++;
        if (item.func != FUNC_TICK)
        begin
            commands_sent++;
        end
    endtask

    task automatic send_tick();
        req_t r;
        r      = random_request();
        r.func = FUNC_TICK;
        send_request(r);
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        while (results_done != reqs_done)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_enable(input logic value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Issues one command and ticks until a result shows the block idle again.
    // Extra commands go in only while the move is certain to be still running.
    task automatic run_move(input func_t f, input logic [15:0] count, input logic back,
                            input logic [7:0] tgt, input logic [15:0] hp,
                            input int forced_rejects);
        req_t        r;
        int unsigned tgt_mod;
        int unsigned steps;
        int unsigned min_ticks;
        int unsigned ticks_sent;
        int          cmd_idx;
        r                = random_request();
        r.func           = f;
        r.half_period_us = hp;
        tgt_mod          = tgt % DIAL_STEPS;
        if (f == FUNC_MOVE)
        begin
            r.step_count = count;
            r.backward   = back;
            steps        = count;
        end
        else
        begin
            r.target = tgt;
            if (f == FUNC_GOTO_RIGHT)
            begin
                steps = (last_pos + DIAL_STEPS - tgt_mod) % DIAL_STEPS;
            end
            else
            begin
                steps = (tgt_mod + DIAL_STEPS - last_pos) % DIAL_STEPS;
            end
        end
        send_request(r);
        cmd_idx = reqs_done - 1;
        if (steps != 0)
        begin
            repeat (forced_rejects) send_request(random_command());
        end
        min_ticks  = 2 * steps * ((hp == 0) ? 1 : hp);
        ticks_sent = 0;
        while (last_idle_idx < cmd_idx)
        begin
            if (ticks_sent < min_ticks && $urandom_range(99) < 5)
            begin
                send_request(random_command());
            end
            else
            begin
                send_tick();
                ticks_sent++;
            end
        end
    endtask

    task automatic random_sequence();
        func_t       f;
        logic [15:0] count;
        logic [15:0] hp;
        int          pick;
        int          t;
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            pick = $urandom_range(99);
            f = (pick < 50) ? FUNC_MOVE : (pick < 75) ? FUNC_GOTO_RIGHT : FUNC_GOTO_LEFT;
            pick  = $urandom_range(99);
            count = (pick < 10) ? 16'd0 :
                    (pick < 95) ? 16'($urandom_range(8, 1)) : 16'($urandom_range(40, 9));
            pick = $urandom_range(99);
            hp   = (pick < 40) ? 16'd0 :
                   (pick < 75) ? 16'($urandom_range(2, 1)) :
                   (pick < 95) ? 16'($urandom_range(5, 3)) : 16'($urandom_range(20, 6));
            if (count > 8)
            begin
                hp = hp % 3;
            end
            if ($urandom_range(99) < 10)
            begin
                t  = $urandom_range(255);
                hp = 16'($urandom_range(1));
            end
            else
            begin
                t = $urandom_range(8, 1);
                t = (int'(last_pos) + DIAL_STEPS + ($urandom_range(1) ? t : -t)) % DIAL_STEPS;
                if (t + DIAL_STEPS <= 255 && $urandom_range(99) < 30)
                begin
                    t = t + DIAL_STEPS;
                end
            end
            run_move(f, count, 1'($urandom), 8'(t), hp, 0);
        end
        else if (pick < 92)
        begin
            repeat ($urandom_range(5, 1)) send_tick();
        end
        else if ($urandom_range(1))
        begin
            run_move(FUNC_MOVE, 16'd0, 1'($urandom), 8'($urandom), 16'($urandom), 0);
        end
        else
        begin
            t = last_pos;
            if (t + DIAL_STEPS <= 255 && $urandom_range(1))
            begin
                t = t + DIAL_STEPS;
            end
            f = $urandom_range(1) ? FUNC_GOTO_RIGHT : FUNC_GOTO_LEFT;
            run_move(f, 16'($urandom), 1'($urandom), 8'(t), 16'($urandom), 0);
        end
    endtask

    initial
    begin : stimulus
        req_t r;
        int   phase_end;
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= 1'b0;
        req_valid  <= 1'b0;
        req        <= '0;
        end_of_run <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 24;
        recv_stall_pct = 62;
        write_enable(1'b0);

        r                = random_request();
        r.func           = FUNC_TICK;
        r.step_count     = '1;
        r.backward       = 1'b1;
        r.target         = '1;
        r.half_period_us = '1;
        send_request(r);
        run_move(FUNC_MOVE, 16'd0, 1'b1, 8'd0, 16'hFFFF, 0);
        run_move(FUNC_MOVE, 16'd2, 1'b0, 8'd0, 16'd0, 2);
        run_move(FUNC_MOVE, 16'd3, 1'b1, 8'd0, 16'd0, 0);
        run_move(FUNC_GOTO_LEFT, 16'hFFFF, 1'b1, 8'd201, 16'd0, 0);
        run_move(FUNC_GOTO_RIGHT, 16'd0, 1'b0, 8'd201, 16'd0, 0);
        run_move(FUNC_GOTO_RIGHT, 16'd0, 1'b0, 8'd0, 16'd2, 1);
        run_move(FUNC_GOTO_LEFT, 16'hFFFF, 1'b1, 8'd200, 16'hFFFF, 0);
        send_tick();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1:
                begin
                    send_idle_pct  = 62;
                    recv_stall_pct = 24;
                    write_enable(1'b1);
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    write_enable(1'b0);
                end
                3:
                begin
                    write_enable(1'b1);
                end
                default:
                begin
                end
            endcase
            phase_end = reqs_done + RANDOM_ITEMS / 4;
            while (reqs_done < phase_end)
            begin
                random_sequence();
            end
        end

        drain_results();
        repeat (4) @(posedge clk);
        end_of_run <= 1'b1;
        repeat (2) @(posedge clk);

        $display("Run covered %0d requests, %0d of them commands, in four phases of three idle mixes.",
                 reqs_done, commands_sent);
        $display("%0d commands came back rejected; driver enable written four times.",
                 reject_seen);
        if (fail_count == 0)
        begin
            $display("tb_stepper_dial_pulse_generator OK");
        end
        else
        begin
            $display("tb_stepper_dial_pulse_generator NOT OK");
        end
        $finish;
    end

endmodule
